// ===== rtl/cache_tag_lookup_random_replace_unit_defines.svh =====
// Assertion macros shared by the tag lookup unit.
`ifndef CACHE_TAG_LOOKUP_RANDOM_REPLACE_UNIT_DEFINES_SVH
`define CACHE_TAG_LOOKUP_RANDOM_REPLACE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define CTLRR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked outside of reset.
`define CTLRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== rtl/ctlrr_pkg.sv =====
package ctlrr_pkg;

   localparam int LINES_DEFAULT = 64;
   localparam int BLOCK_W       = 32;
   localparam int LINE_INDEX_W  = 6;
   localparam int MAP_MODE_W    = 2;
   localparam int WAYS_LOG2_W   = 3;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 3;
   localparam int LFSR_W        = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

   localparam logic [MAP_MODE_W-1:0] MODE_DIRECT = 2'd0;
   localparam logic [MAP_MODE_W-1:0] MODE_FULL   = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_MODE  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS_LOG2 = 4'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_BLOCK,
      ST_SETUP,
      ST_SCAN,
      ST_DIV_VICTIM,
      ST_WRITE,
      ST_RESP
   } ctlrr_state_type;

   // Fibonacci LFSR, polynomial x^16+x^14+x^13+x^11+1, shifting right.
   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
      logic fb;
      fb = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {fb, v[LFSR_W-1:1]};
   endfunction

endpackage

// ===== rtl/cache_tag_lookup_random_replace_unit.sv =====
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_ready   req_block_number[31:0]
// rsp_      out        rsp_valid / rsp_ready   rsp_hit, rsp_line_index[5:0]
// csr_      in         csr_write_enable        csr_index[3:0], csr_write_data[2:0]
//
// One item at a time. The 32-step shift-subtract divider first splits an accepted block
// number into set and tag; the tag memory, one read per cycle, then scans the set in
// ascending order. A miss writes the tag to a victim line, picked at random by the divider
// when the mode is not direct mapped.
// After reset the unit clears every line of the tag memory before the first transfer.
// A finished result waits in the output register; the next item is taken meanwhile.
module cache_tag_lookup_random_replace_unit #(
   parameter int LINES = ctlrr_pkg::LINES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ctlrr_pkg::BLOCK_W-1:0]        req_block_number,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic [ctlrr_pkg::LINE_INDEX_W-1:0]   rsp_line_index,
   input  logic                                 csr_write_enable,
   input  logic [ctlrr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ctlrr_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   import ctlrr_pkg::*;

`include "cache_tag_lookup_random_replace_unit_defines.svh"

   // LW addresses a line; DW holds a count of lines up to LINES itself.
   localparam int LW     = $clog2(LINES);
   localparam int DW     = $clog2(LINES + 1);
   localparam int DIV_N  = BLOCK_W;
   localparam int CNT_W  = $clog2(DIV_N);
   localparam int ENTRY_W = BLOCK_W + 1;

   // Each entry holds a valid bit on top of the 32-bit tag.
   logic [ENTRY_W-1:0] tag_mem [LINES];
   logic [ENTRY_W-1:0] mem_rdata_ff;
   logic               mem_we;
   logic [LW-1:0]      mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [LW-1:0]      mem_raddr;

   ctlrr_state_type state_ff, state_in;

   logic [MAP_MODE_W-1:0]  map_mode_ff, map_mode_in;
   logic [WAYS_LOG2_W-1:0] ways_log2_ff, ways_log2_in;
   logic [LFSR_W-1:0]      lfsr_ff, lfsr_in;
   logic [LW-1:0]          clr_cnt_ff, clr_cnt_in;

   logic [DW-1:0]      div_rem_ff, div_rem_in;
   logic [DIV_N-1:0]   div_quo_ff, div_quo_in;
   logic [DW-1:0]      div_den_ff, div_den_in;
   logic [CNT_W-1:0]   div_cnt_ff, div_cnt_in;

   logic [BLOCK_W-1:0]     tag_ff, tag_in;
   logic [LW-1:0]          base_ff, base_in;
   logic [DW-1:0]          ways_ff, ways_in;
   logic [WAYS_LOG2_W-1:0] shift_ff, shift_in;
   logic                   full_ff, full_in;
   logic                   dir_ff, dir_in;

   logic [DW-1:0] scan_cnt_ff, scan_cnt_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          rd_last_ff, rd_last_in;
   logic [LW-1:0] rd_line_ff, rd_line_in;

   logic          res_hit_ff, res_hit_in;
   logic [LW-1:0] res_line_ff, res_line_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [LINE_INDEX_W-1:0] rsp_line_index_ff, rsp_line_index_in;

   // Helper terms.
   logic                   accept;
   logic                   rsp_free;
   logic                   div_done;
   logic [DW:0]            div_trial;
   logic                   div_ge;
   logic [DW-1:0]          div_rem_step;
   logic                   scan_issue;
   logic [LW-1:0]          scan_addr;
   logic                   rd_match;
   logic                   rd_miss_done;
   logic [LW-1:0]          victim_line;
   logic                   geo_full;
   logic [WAYS_LOG2_W-1:0] geo_shift;
   logic [DW-1:0]          geo_ways;
   logic [DW-1:0]          geo_sets;

   // Geometry from the mode registers. A set-associative way count that would
   // exceed the store collapses into one fully associative set.
   always_comb begin
      geo_full  = 1'b0;
      geo_shift = '0;
      if (map_mode_ff == MODE_FULL) begin
         geo_full = 1'b1;
      end else if (map_mode_ff != MODE_DIRECT) begin
         geo_shift = ways_log2_ff;
         geo_full  = (32'(ways_log2_ff) > 32'(DW - 1));
      end
      geo_ways = geo_full ? DW'(LINES) : (DW'(1) << geo_shift);
      geo_sets = geo_full ? DW'(1) : (DW'(LINES) >> geo_shift);
   end

   // Restoring divider, one quotient bit per cycle. It splits the block number
   // into set and tag, and later reduces the LFSR value modulo the way count.
   assign div_trial    = {div_rem_ff, div_quo_ff[DIV_N-1]};
   assign div_ge       = (div_trial >= {1'b0, div_den_ff});
   assign div_rem_step = div_ge ? DW'(div_trial - {1'b0, div_den_ff}) : DW'(div_trial);
   assign div_done     = (div_cnt_ff == CNT_W'(DIV_N - 1));

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Lines of the set are read in ascending order; each compare follows in the cycle after its read.
   assign scan_addr    = base_ff + LW'(scan_cnt_ff);
   assign scan_issue   = (state_ff == ST_SCAN) && (scan_cnt_ff < ways_ff);
   assign rd_match     = rd_pend_ff && mem_rdata_ff[BLOCK_W] &&
                         (mem_rdata_ff[BLOCK_W-1:0] == tag_ff);
   assign rd_miss_done = rd_pend_ff && !rd_match && rd_last_ff;
   assign victim_line  = dir_ff ? base_ff : (base_ff + LW'(div_rem_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LW'(LINES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIV_BLOCK;
            end
         end
         ST_DIV_BLOCK: begin
            if (div_done) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            priority if (rd_match) begin
               state_in = ST_RESP;
            end else if (rd_miss_done) begin
               state_in = dir_ff ? ST_WRITE : ST_DIV_VICTIM;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_DIV_VICTIM: begin
            if (div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs: handshake and memory ports.
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = victim_line;
      mem_wdata = {1'b1, tag_ff};
      mem_raddr = scan_addr;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_WRITE: begin
            mem_we = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      map_mode_in       = map_mode_ff;
      ways_log2_in      = ways_log2_ff;
      lfsr_in           = lfsr_ff;
      clr_cnt_in        = clr_cnt_ff;
      div_rem_in        = div_rem_ff;
      div_quo_in        = div_quo_ff;
      div_den_in        = div_den_ff;
      div_cnt_in        = div_cnt_ff;
      tag_in            = tag_ff;
      base_in           = base_ff;
      ways_in           = ways_ff;
      shift_in          = shift_ff;
      full_in           = full_ff;
      dir_in            = dir_ff;
      scan_cnt_in       = scan_cnt_ff;
      rd_pend_in        = 1'b0;
      rd_last_in        = rd_last_ff;
      rd_line_in        = rd_line_ff;
      res_hit_in        = res_hit_ff;
      res_line_in       = res_line_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_hit_in        = rsp_hit_ff;
      rsp_line_index_in = rsp_line_index_ff;

      if (csr_write_enable) begin
         if (csr_index == CSR_MAP_MODE) begin
            map_mode_in = csr_write_data[MAP_MODE_W-1:0];
         end else if (csr_index == CSR_WAYS_LOG2) begin
            ways_log2_in = csr_write_data[WAYS_LOG2_W-1:0];
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + LW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               div_quo_in = req_block_number;
               div_rem_in = '0;
               div_den_in = geo_sets;
               div_cnt_in = '0;
               ways_in    = geo_ways;
               shift_in   = geo_shift;
               full_in    = geo_full;
               dir_in     = (map_mode_ff == MODE_DIRECT);
            end
         end
         ST_DIV_BLOCK, ST_DIV_VICTIM: begin
            div_quo_in = {div_quo_ff[DIV_N-2:0], div_ge};
            div_rem_in = div_rem_step;
            div_cnt_in = div_cnt_ff + CNT_W'(1);
         end
         ST_SETUP: begin
            // Quotient is the tag, remainder the set; the set starts at set * ways.
            tag_in      = div_quo_ff;
            base_in     = full_ff ? '0 : LW'(div_rem_ff << shift_ff);
            scan_cnt_in = '0;
         end
         ST_SCAN: begin
            if (scan_issue) begin
               scan_cnt_in = scan_cnt_ff + DW'(1);
               rd_pend_in  = 1'b1;
               rd_line_in  = scan_addr;
               rd_last_in  = (scan_cnt_ff == (ways_ff - DW'(1)));
            end
            priority if (rd_match) begin
               res_hit_in  = 1'b1;
               res_line_in = rd_line_ff;
            end else if (rd_miss_done) begin
               res_hit_in = 1'b0;
               if (!dir_ff) begin
                  // Random replacement: step the LFSR, then reduce it modulo ways.
                  lfsr_in    = lfsr_next(lfsr_ff);
                  div_quo_in = DIV_N'(lfsr_next(lfsr_ff));
                  div_rem_in = '0;
                  div_den_in = ways_ff;
                  div_cnt_in = '0;
               end
            end else begin
               res_hit_in = res_hit_ff;
            end
         end
         ST_WRITE: begin
            res_line_in = victim_line;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_hit_in        = res_hit_ff;
               rsp_line_index_in = LINE_INDEX_W'(res_line_ff);
            end
         end
         default: begin
            clr_cnt_in = clr_cnt_ff;
         end
      endcase
   end

   // Tag memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= tag_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         map_mode_ff  <= MODE_DIRECT;
         ways_log2_ff <= WAYS_LOG2_W'(1);
         lfsr_ff      <= LFSR_SEED;
         clr_cnt_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_mode_ff  <= map_mode_in;
         ways_log2_ff <= ways_log2_in;
         lfsr_ff      <= lfsr_in;
         clr_cnt_ff   <= clr_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff        <= div_rem_in;
      div_quo_ff        <= div_quo_in;
      div_den_ff        <= div_den_in;
      div_cnt_ff        <= div_cnt_in;
      tag_ff            <= tag_in;
      base_ff           <= base_in;
      ways_ff           <= ways_in;
      shift_ff          <= shift_in;
      full_ff           <= full_in;
      dir_ff            <= dir_in;
      scan_cnt_ff       <= scan_cnt_in;
      rd_last_ff        <= rd_last_in;
      rd_line_ff        <= rd_line_in;
      res_hit_ff        <= res_hit_in;
      res_line_ff       <= res_line_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_line_index_ff <= rsp_line_index_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_line_index = rsp_line_index_ff;

   // The LFSR can never lock up at zero.
   `CTLRR_ASSERT_IMPL(a_lfsr_nonzero, clock, reset, 1'b1, lfsr_ff != '0)
   // A direct-mapped lookup never moves the LFSR.
   `CTLRR_ASSERT_NEXT(a_direct_lfsr_still, clock, reset,
                      (state_ff == ST_SCAN) && dir_ff, $stable(lfsr_ff))
   // The scan never reads past the end of the set.
   `CTLRR_ASSERT_IMPL(a_scan_bound, clock, reset, state_ff == ST_SCAN, scan_cnt_ff <= ways_ff)
   // An accepted transfer always starts the block division.
   `CTLRR_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == ST_DIV_BLOCK)

endmodule
